// ===== sv/prefix_code_bit_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_core_defines.svh
// Assertion macros used by the checker file of the prefix code decoder.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_DECODER_CORE_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_CORE_DEFINES_SVH

// Clocked assertion, held off while reset is high.
`define PCBD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("prefix code decoder check failed");

// Clocked assertion that also holds across reset.
`define PCBD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prefix code decoder reset check failed");

`endif

// ===== sv/pcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbd_pkg
// Shared widths, codes, types and helpers of the prefix code bit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcbd_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W    = 5;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int EIU_W    = 6;
  localparam int CMP_W    = 6;   // holds any code length up to 32
  localparam int WIDE_W   = 32;  // compare width for prefix against code
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  // Parameter defaults
  localparam int TABLE_ENTRIES_DEF   = 32;
  localparam int MAX_CODE_LENGTH_DEF = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register map
  localparam logic [APB_AW-1:0] ADDR_ENTRIES_IN_USE = 2'd0;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BIT  = 1'b1;

  typedef struct packed {
    logic              usable;   // symbol nonzero and length legal
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;     // already masked to its length
    logic [LEN_W-1:0]  length;
  } slot_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index;
    slot_t            slot;
    logic             code_bit;
  } q_item_t;

  // Low mask of len bits over the code width
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W:0] one_hot;
    one_hot = (CODE_W+1)'(1) << len;
    if (len >= LEN_W'(CODE_W)) begin
      code_mask = '1;
    end else begin
      code_mask = CODE_W'(one_hot - (CODE_W+1)'(1));
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/prefix_code_bit_decoder_core.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_core
// Table-driven prefix code decoder taking one code bit per cycle when no stall holds it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries two kinds of item. A load item
//   (req_type = 0) writes one table slot: symbol, code bits, code length. A
//   bit item (req_type = 1) appends code_bit to the running prefix, first bit
//   most significant. The prefix is matched against slots 0 .. entries_in_use-1
//   on exact length and bits; a hit returns the symbol and clears the prefix,
//   and reaching MAX_CODE_LENGTH bits without a hit returns overflow = 1 with
//   symbol = 0. Loads and unmatched bits return nothing.
//   Throughput is one item per cycle unless a stall holds the flow: all slots
//   are compared in parallel in the back end in the cycle the bit leaves the
//   queue, and the result is registered onto out_valid / symbol / overflow.
//   A four-entry queue parts the front from the back; in_stall rises only
//   when that queue is full. While out_stall holds a result, loads keep
//   draining and the next bit item waits at the head of the queue.
//   Reset (rst, synchronous) empties the queue, clears the prefix, drops any
//   pending result and sets entries_in_use to zero. Table slots are not
//   cleared; load every slot in use before decoding. Write entries_in_use over
//   APB at address 0 only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_bit_decoder_core #(
  parameter int TABLE_ENTRIES   = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LENGTH = pcbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcbd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [pcbd_pkg::APB_DW-1:0]   pwdata,
  output logic [pcbd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [pcbd_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [pcbd_pkg::SYM_W-1:0]    entry_symbol,
  input  wire logic [pcbd_pkg::CODE_W-1:0]   entry_code,
  input  wire logic [pcbd_pkg::LEN_W-1:0]    entry_length,
  input  wire logic                          code_bit,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pcbd_pkg::SYM_W-1:0]         symbol,
  output logic                               overflow
);

  logic [pcbd_pkg::EIU_W-1:0] entries_in_use;
  logic                       cfg_wr;
  logic                       q_full;
  logic                       push_valid;
  pcbd_pkg::q_item_t          push_item;
  logic                       q_valid;
  pcbd_pkg::q_item_t          q_head;
  logic                       pop;

  // Configuration register: zero-wait APB, one register at address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == pcbd_pkg::ADDR_ENTRIES_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_wr) begin
      entries_in_use <= pwdata[pcbd_pkg::EIU_W-1:0];
    end
  end

  // Return the register at its address, zero elsewhere
  assign prdata = (paddr == pcbd_pkg::ADDR_ENTRIES_IN_USE) ?
                  pcbd_pkg::APB_DW'(entries_in_use) : '0;

  // Front: accept and classify items
  pcbd_front #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_symbol (entry_symbol),
    .entry_code   (entry_code),
    .entry_length (entry_length),
    .code_bit     (code_bit),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  // Queue: decouple front stalls from back stalls
  pcbd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop)
  );

  // Back: table writes, prefix tracking, match and result register
  pcbd_back #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entries_in_use (entries_in_use),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol         (symbol),
    .overflow       (overflow)
  );

endmodule

`default_nettype wire

// ===== sv/pcbd_front.sv =====
// ----------------------------------------------------------------------------
// pcbd_front
// Accepts items, drops loads to missing slots and prepares table entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbd_front #(
  parameter int TABLE_ENTRIES   = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LENGTH = pcbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [pcbd_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [pcbd_pkg::SYM_W-1:0]    entry_symbol,
  input  wire logic [pcbd_pkg::CODE_W-1:0]   entry_code,
  input  wire logic [pcbd_pkg::LEN_W-1:0]    entry_length,
  input  wire logic                          code_bit,
  input  wire logic                          q_full,
  output logic                               push_valid,
  output pcbd_pkg::q_item_t                  push_item
);

  localparam int SLOTS = (TABLE_ENTRIES < (1 << pcbd_pkg::IDX_W)) ?
                         TABLE_ENTRIES : (1 << pcbd_pkg::IDX_W);

  logic drop;

  // Loads past the last slot are taken and thrown away
  assign drop = (req_type == pcbd_pkg::KIND_LOAD) &&
                (pcbd_pkg::CMP_W'(entry_index) >= pcbd_pkg::CMP_W'(SLOTS));

  assign in_stall   = q_full;
  assign push_valid = in_valid && !drop;

  always_comb begin
    push_item             = '0;
    push_item.kind        = req_type;
    push_item.index       = entry_index;
    push_item.code_bit    = code_bit;
    push_item.slot.symbol = entry_symbol;
    push_item.slot.length = entry_length;
    push_item.slot.code   = entry_code & pcbd_pkg::code_mask(entry_length);
    push_item.slot.usable = (entry_symbol != '0) && (entry_length != '0) &&
                            (pcbd_pkg::CMP_W'(entry_length) <=
                             pcbd_pkg::CMP_W'(MAX_CODE_LENGTH));
  end

endmodule

`default_nettype wire

// ===== sv/pcbd_fifo.sv =====
// ----------------------------------------------------------------------------
// pcbd_fifo
// Short in-order queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire pcbd_pkg::q_item_t push_item,
  output logic                   q_full,
  output logic                   q_valid,
  output pcbd_pkg::q_item_t      q_head,
  input  wire logic              pop
);

  localparam int DEPTH = pcbd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcbd_pkg::q_item_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = mem[rd_ptr];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcbd_back.sv =====
// ----------------------------------------------------------------------------
// pcbd_back
// Holds the code table and prefix, matches each bit, registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbd_back #(
  parameter int TABLE_ENTRIES   = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LENGTH = pcbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pcbd_pkg::EIU_W-1:0]    entries_in_use,
  input  wire logic                          q_valid,
  input  wire pcbd_pkg::q_item_t             q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pcbd_pkg::SYM_W-1:0]         symbol,
  output logic                               overflow
);

  localparam int SLOTS  = (TABLE_ENTRIES < (1 << pcbd_pkg::IDX_W)) ?
                          TABLE_ENTRIES : (1 << pcbd_pkg::IDX_W);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PW     = MAX_CODE_LENGTH;
  localparam int LW     = $clog2(MAX_CODE_LENGTH + 1);

  pcbd_pkg::slot_t             code_table [SLOTS];
  logic [PW-1:0]               prefix_bits;
  logic [LW-1:0]               prefix_length;
  logic [PW-1:0]               bits_next;
  logic [LW-1:0]               length_next;
  logic [SLOTS-1:0]            hit;
  logic                        hit_any;
  logic [pcbd_pkg::SYM_W-1:0]  hit_symbol;
  logic                        ovf_now;
  logic                        is_bit;
  logic                        out_free;

  assign is_bit   = (q_head.kind == pcbd_pkg::KIND_BIT);
  assign out_free = !out_valid || !out_stall;
  // Loads never wait on the output; bit items need room for a result
  assign pop      = q_valid && (!is_bit || out_free);

  // The stored prefix is always shorter than the maximum, so no mask needed
  assign bits_next   = {prefix_bits[PW-2:0], q_head.code_bit};
  assign length_next = prefix_length + LW'(1);

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = code_table[k].usable &&
               (pcbd_pkg::CMP_W'(k) < pcbd_pkg::CMP_W'(entries_in_use)) &&
               (pcbd_pkg::CMP_W'(code_table[k].length) ==
                pcbd_pkg::CMP_W'(length_next)) &&
               (pcbd_pkg::WIDE_W'(code_table[k].code) ==
                pcbd_pkg::WIDE_W'(bits_next));
    end
  end

  // Lowest matching slot wins
  always_comb begin
    hit_any    = 1'b0;
    hit_symbol = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_any    = 1'b1;
        hit_symbol = code_table[k].symbol;
      end
    end
  end

  assign ovf_now = !hit_any && (length_next == LW'(MAX_CODE_LENGTH));

  always_ff @(posedge clk) begin
    if (pop && !is_bit) begin
      code_table[q_head.index[SLOT_W-1:0]] <= q_head.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bits   <= '0;
      prefix_length <= '0;
    end else if (pop && is_bit) begin
      if (hit_any || ovf_now) begin
        prefix_bits   <= '0;
        prefix_length <= '0;
      end else begin
        prefix_bits   <= bits_next;
        prefix_length <= length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_bit && (hit_any || ovf_now)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_bit && (hit_any || ovf_now)) begin
      symbol   <= hit_symbol;
      overflow <= ovf_now;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcbd_checker.sv =====
// ----------------------------------------------------------------------------
// pcbd_checker
// Port-level checks of the prefix code decoder result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "prefix_code_bit_decoder_core_defines.svh"

module pcbd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [pcbd_pkg::SYM_W-1:0] symbol,
  input wire logic                       overflow
);

  // A stalled result stays put
  `PCBD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(overflow))

  // Overflow results carry a zero symbol
  `PCBD_ASSERT(a_ovf_zero, clk, rst, out_valid && overflow |-> symbol == '0)

  // Absent entries never match, so a decoded symbol is never zero
  `PCBD_ASSERT(a_sym_nonzero, clk, rst, out_valid && !overflow |-> symbol != '0)

  // Nothing is presented right after a reset edge
  `PCBD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind prefix_code_bit_decoder_core pcbd_checker u_pcbd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .overflow  (overflow)
);

`default_nettype wire

// ===== test/prefix_code_bit_decoder_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_core_checker
// Watches the item, result and APB channels of the prefix code decoder. It
// keeps its own copy of the code table, prefix and entries_in_use, predicts
// the result of every accepted code bit and compares results in order.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_core_checker #(
  parameter int TABLE_ENTRIES   = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LENGTH = pcbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcbd_pkg::APB_AW-1:0]   paddr,
  input  logic [pcbd_pkg::APB_DW-1:0]   pwdata,
  input  logic [pcbd_pkg::APB_DW-1:0]   prdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          req_type,
  input  logic [pcbd_pkg::IDX_W-1:0]    entry_index,
  input  logic [pcbd_pkg::SYM_W-1:0]    entry_symbol,
  input  logic [pcbd_pkg::CODE_W-1:0]   entry_code,
  input  logic [pcbd_pkg::LEN_W-1:0]    entry_length,
  input  logic                          code_bit,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pcbd_pkg::SYM_W-1:0]    symbol,
  input  logic                          overflow,
  output int                            fail_count,
  output int                            pending,
  output int                            symbols_seen,
  output int                            overflows_seen
);
  import pcbd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             overflow;
  } decode_result_t;

  logic [SYM_W-1:0]  tab_symbol [TABLE_ENTRIES];
  logic [CODE_W-1:0] tab_code   [TABLE_ENTRIES];
  logic [LEN_W-1:0]  tab_length [TABLE_ENTRIES];
  logic [31:0]       acc_bits;
  int                acc_len;
  logic [EIU_W-1:0]  entries_live;
  decode_result_t    expected_q [$];
  int                fails = 0;

  function automatic logic [31:0] len_mask(input int n);
    if (n >= 32) return '1;
    return (32'd1 << n) - 32'd1;
  endfunction

  // Append one bit and match the prefix against the live slots.
  task automatic decode_next_bit(input logic b, output bit produced,
                                 output decode_result_t res);
    int          limit;
    int          hit;
    logic [31:0] m;
    acc_bits = (acc_bits << 1) | 32'(b);
    if (acc_len < MAX_CODE_LENGTH) acc_len++;
    m = len_mask(acc_len);
    acc_bits = acc_bits & m;
    limit = (int'(entries_live) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_live);
    hit = -1;
    for (int k = 0; k < limit; k++) begin
      if (hit < 0 && tab_symbol[k] != '0 && tab_length[k] != '0 &&
          int'(tab_length[k]) <= MAX_CODE_LENGTH && int'(tab_length[k]) == acc_len &&
          (32'(tab_code[k]) & m) == acc_bits) begin
        hit = k;
      end
    end
    produced = 1'b1;
    res = '0;
    if (hit >= 0) begin
      res.symbol = tab_symbol[hit];
      acc_bits = '0;
      acc_len = 0;
    end else if (acc_len >= MAX_CODE_LENGTH) begin
      res.overflow = 1'b1;
      acc_bits = '0;
      acc_len = 0;
    end else begin
      produced = 1'b0;
    end
  endtask

  always @(posedge clk) begin : track
    decode_result_t want;
    bit             produced;
    if (rst) begin
      acc_bits = '0;
      acc_len = 0;
      entries_live = '0;
      expected_q.delete();
    end else begin
      // Results first: nothing accepted on this edge can already have one.
      if (out_valid && !out_stall) begin
        if (overflow) overflows_seen <= overflows_seen + 1;
        else symbols_seen <= symbols_seen + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result: symbol %0h overflow %0b", symbol, overflow);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (symbol !== want.symbol) begin
            $error("symbol mismatch: expected %0h, got %0h", want.symbol, symbol);
            fails++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, got %0b", want.overflow, overflow);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type == KIND_LOAD) begin
          if (int'(entry_index) < TABLE_ENTRIES) begin
            tab_symbol[entry_index] = entry_symbol;
            tab_code[entry_index]   = entry_code;
            tab_length[entry_index] = entry_length;
          end
        end else begin
          decode_next_bit(code_bit, produced, want);
          if (produced) expected_q.push_back(want);
        end
      end
      if (psel && penable && pready && paddr == ADDR_ENTRIES_IN_USE) begin
        if (pwrite) begin
          entries_live = pwdata[EIU_W-1:0];
        end else if (prdata[EIU_W-1:0] !== entries_live) begin
          $error("entries_in_use readback mismatch: expected %0d, got %0d",
                 entries_live, prdata[EIU_W-1:0]);
          fails++;
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= fails;
  end

endmodule

// ===== test/prefix_code_bit_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_core_tb
// Drives table loads, code bits and entries_in_use writes into the prefix
// code decoder with random gaps and stalls on both channels; the checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_core_tb;
  import pcbd_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake of any kind
  localparam int DRAIN_CYCLES = 12;    // drain time of the queue and the back end, with margin
  localparam int LONG_HOLD    = 90;    // receiver hold-off that backs up the queue
  localparam int BODY_ITEMS   = 140;   // random items per table setting
  localparam int NUM_PHASES   = 10;
  localparam int MAX_WAIT     = 17;

  typedef enum int {FLAW_ABSENT, FLAW_BAD_LENGTH, FLAW_DUPLICATE} flaw_t;

  // Register settings of the random phases: low counts, full table, and
  // values above the table size that must act as a full table.
  localparam int PHASE_LIVE [NUM_PHASES] = '{1, 2, 32, 17, 63, 5, 40, 32, 9, 32};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = KIND_LOAD;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [SYM_W-1:0]  entry_symbol = '0;
  logic [CODE_W-1:0] entry_code = '0;
  logic [LEN_W-1:0]  entry_length = '0;
  logic              code_bit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SYM_W-1:0]  symbol;
  logic              overflow;

  int fail_count;
  int pending;
  int symbols_seen;
  int overflows_seen;

  int items_sent = 0;
  int loads_sent = 0;
  int bits_sent = 0;
  int sender_quiet = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int idle_cycles = 0;

  // Prefix-free code built for the current phase, one leaf per live slot.
  logic [31:0] tree_code [TABLE_ENTRIES_DEF];
  int          tree_len  [TABLE_ENTRIES_DEF];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  prefix_code_bit_decoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_symbol (entry_symbol),
    .entry_code   (entry_code),
    .entry_length (entry_length),
    .code_bit     (code_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .overflow     (overflow)
  );

  prefix_code_bit_decoder_core_checker decode_check (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .entry_index    (entry_index),
    .entry_symbol   (entry_symbol),
    .entry_code     (entry_code),
    .entry_length   (entry_length),
    .code_bit       (code_bit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol         (symbol),
    .overflow       (overflow),
    .fail_count     (fail_count),
    .pending        (pending),
    .symbols_seen   (symbols_seen),
    .overflows_seen (overflows_seen)
  );

  // Draw the wait before the next item on one side. A side sometimes enters
  // a quiet stretch of back-to-back items; otherwise waits are short, with
  // an occasional long one up to MAX_WAIT.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MAX_WAIT);
    return $urandom_range(0, 1);
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                           input logic [LEN_W-1:0] len, input logic b);
    int gap;
    gap = draw_wait(sender_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type     <= kind;
    entry_index  <= idx;
    entry_symbol <= sym;
    entry_code   <= code;
    entry_length <= len;
    code_bit     <= b;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (kind == KIND_BIT) bits_sent++;
    else loads_sent++;
  endtask

  // Bit items carry random junk in the entry fields; the block must ignore it.
  task automatic send_bit(input logic b);
    send_item(KIND_BIT, IDX_W'($urandom), SYM_W'($urandom), CODE_W'($urandom),
              LEN_W'($urandom), b);
  endtask

  task automatic send_load(input int idx, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    send_item(KIND_LOAD, IDX_W'(idx), sym, code, len, 1'($urandom));
  endtask

  // Drop valid, wait for every expected result, then let any trailing
  // unmatched bits drain through the queue.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer to entries_in_use: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_ENTRIES_IN_USE;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Build a complete prefix code over the live slots by splitting leaves,
  // then load all slots: live ones with the code (junk above the length,
  // a few with a flaw), the rest with arbitrary content.
  task automatic load_phase_table(input int live, input bit skewed);
    int                leaves;
    int                pick;
    int                j;
    flaw_t             flaw;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    tree_len[0]  = (live == 1) ? $urandom_range(1, MAX_CODE_LENGTH_DEF) : 0;
    tree_code[0] = $urandom & ((32'd1 << tree_len[0]) - 32'd1);
    leaves = 1;
    while (leaves < live) begin
      // Skewed trees keep splitting the newest leaf, which yields long codes.
      pick = skewed ? leaves - 1 : $urandom_range(0, leaves - 1);
      while (tree_len[pick] >= MAX_CODE_LENGTH_DEF) pick = $urandom_range(0, leaves - 1);
      tree_code[leaves] = (tree_code[pick] << 1) | 32'd1;
      tree_len[leaves]  = tree_len[pick] + 1;
      tree_code[pick]   = tree_code[pick] << 1;
      tree_len[pick]++;
      leaves++;
    end
    for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
      if (k < live) begin
        sym  = SYM_W'($urandom_range(1, 255));
        len  = LEN_W'(tree_len[k]);
        code = CODE_W'(tree_code[k] | ($urandom << tree_len[k]));
        if ($urandom_range(0, 9) == 0) begin
          flaw = flaw_t'($urandom_range(0, 2));
          if (flaw == FLAW_DUPLICATE && k > 0) begin
            // Same codeword as an earlier slot: the earlier one must win.
            j    = $urandom_range(0, k - 1);
            code = tree_code[j][CODE_W-1:0];
            len  = LEN_W'(tree_len[j]);
          end else if (flaw == FLAW_BAD_LENGTH) begin
            len = ($urandom_range(0, 1) == 0) ? LEN_W'(0)
                                              : LEN_W'($urandom_range(MAX_CODE_LENGTH_DEF + 1, 31));
          end else begin
            sym = '0;
          end
        end
      end else begin
        sym  = SYM_W'($urandom);
        code = CODE_W'($urandom);
        len  = LEN_W'($urandom);
      end
      send_load(k, sym, code, len);
    end
  endtask

  // Mostly whole codewords of the phase's code, plus stray bits and
  // occasional table rewrites in the middle of the stream.
  task automatic run_phase_body(input int live);
    int sent;
    int slot;
    int r;
    sent = 0;
    while (sent < BODY_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80 && live > 0) begin
        slot = $urandom_range(0, live - 1);
        for (int i = tree_len[slot] - 1; i >= 0; i--) send_bit(tree_code[slot][i]);
        sent += tree_len[slot];
      end else if (r < 97) begin
        send_bit(1'($urandom));
        sent++;
      end else begin
        slot = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
        if (slot < live && $urandom_range(0, 1) == 0)
          send_load(slot, SYM_W'($urandom_range(1, 255)), tree_code[slot][CODE_W-1:0],
                    LEN_W'(tree_len[slot]));
        else
          send_load(slot, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
        sent++;
      end
    end
  endtask

  // Result side: stall for a drawn number of cycles, then take one result.
  // A pending hold-off request replaces the draw with a long stall.
  initial begin : result_sink
    int hold;
    int sink_quiet;
    sink_quiet = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (holds_served < holds_requested) begin
        hold = LONG_HOLD;
        holds_served++;
      end else begin
        hold = draw_wait(sink_quiet);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles, %0d results still pending", idle_cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int live;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table in use: sixteen mixed bits give no symbol, then overflow.
    apb_access(1'b1, 0);
    apb_access(1'b0, 0);
    for (int i = 0; i < MAX_CODE_LENGTH_DEF; i++) send_bit(1'(i));

    // Hand-made table covering the corner entries:
    //   slot 0 zero length, slot 1 absent symbol, slot 2 one-bit code with
    //   junk above its length, slot 3 same code (loses to slot 2), slot 4
    //   all-ones code of two bits, slot 5 length beyond the maximum.
    send_load(0, 8'h01, 16'h0000, 5'd0);
    send_load(1, 8'h00, 16'h0000, 5'd1);
    send_load(2, 8'hFF, 16'hFFFE, 5'd1);
    send_load(3, 8'h11, 16'h0000, 5'd1);
    send_load(4, 8'h22, 16'hFFFF, 5'd2);
    send_load(5, 8'h33, 16'h0001, 5'd17);
    settle();
    apb_access(1'b1, 6);
    apb_access(1'b0, 0);
    // A load between two bits must leave the partial prefix alone.
    send_bit(1'b1);
    send_load(31, 8'h44, 16'h0000, 5'd31);
    send_bit(1'b1);
    send_bit(1'b0);

    // Random phases, each with a fresh code and register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      apb_access(1'b1, PHASE_LIVE[p]);
      apb_access(1'b0, 0);
      live = (PHASE_LIVE[p] > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : PHASE_LIVE[p];
      load_phase_table(live, (p % 4) == 3);
      if (p == 2) begin
        // Back up the block: long receiver hold while items keep coming.
        holds_requested++;
        sender_quiet = 80;
      end
      run_phase_body(live);
    end

    settle();
    $display("Covered %0d items (%0d table loads, %0d code bits) over %0d register settings",
             items_sent, loads_sent, bits_sent, NUM_PHASES + 2);
    $display("Checked %0d decoded symbols and %0d overflow results",
             symbols_seen, overflows_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== prefix_code_bit_decoder_core.f =====
+incdir+sv
sv/pcbd_pkg.sv
sv/pcbd_front.sv
sv/pcbd_fifo.sv
sv/pcbd_back.sv
sv/prefix_code_bit_decoder_core.sv
sv/pcbd_checker.sv
test/prefix_code_bit_decoder_core_checker.sv
test/prefix_code_bit_decoder_core_tb.sv
